// ===== sv/ufpc_pkg.sv =====
// Package for the union-find engine: cell index type, command codes and the
// structs that pass between the sequencer, the parent table and the top level.
// No dependencies.
`timescale 1ns / 1ps

package ufpc_pkg;

  localparam int IDX_W       = 10;
  localparam int TABLE_DEPTH = 1 << IDX_W;

  typedef logic [IDX_W-1:0] idx_t;

  localparam logic CMD_FIND = 1'b0;
  localparam logic CMD_JOIN = 1'b1;

  // One write port and one read port of the parent table.
  typedef struct packed {
    logic we;
    idx_t waddr;
    idx_t wdata;
    idx_t raddr;
  } mem_req_t;

  // Finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic valid;
    idx_t root;
    logic merged;
  } res_t;

endpackage

// ===== sv/ufpc_mem.sv =====
// Parent table of the union-find engine: 1024 x 10-bit memory, one write and
// one registered read port. Depends on ufpc_pkg.
`timescale 1ns / 1ps

module ufpc_mem (
  input  logic              clk,
  input  ufpc_pkg::mem_req_t req,
  output ufpc_pkg::idx_t    rd_data
);
  import ufpc_pkg::*;

  idx_t mem_r [TABLE_DEPTH];
  idx_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  // A read of the entry written in the same cycle returns the new value.
  always_ff @(posedge clk) begin
    if (req.we && (req.waddr == req.raddr)) begin
      rd_data_r <= req.wdata;
    end else begin
      rd_data_r <= mem_r[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/ufpc_seq.sv =====
// Sequencer of the union-find engine: clearing pass, root walk, path
// compression and linking over the shared parent table. Depends on ufpc_pkg.
`timescale 1ns / 1ps

module ufpc_seq #(
  parameter int CELL_COUNT = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  ufpc_pkg::idx_t     in_a,
  input  ufpc_pkg::idx_t     in_b,
  input  logic               out_free,
  output ufpc_pkg::res_t     res,
  output ufpc_pkg::mem_req_t mem_req,
  input  ufpc_pkg::idx_t     rd_data
);
  import ufpc_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_COMP  = 3'd3;
  localparam logic [2:0] S_LINK  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [IDX_W:0] CntW     = (IDX_W+1)'(CELL_COUNT);
  localparam idx_t           LastCell = IDX_W'(CELL_COUNT - 1);

  function automatic logic in_grid(input idx_t v);
    return {1'b0, v} < CntW;
  endfunction

  logic [2:0] state_r, state_nxt;
  idx_t       clr_r, clr_nxt;
  logic       cmd_r, cmd_nxt;
  idx_t       a_r, a_nxt;
  idx_t       b_r, b_nxt;
  idx_t       r_r, r_nxt;     // walk node, then root
  idx_t       c_r, c_nxt;     // node being compressed
  idx_t       ra_r, ra_nxt;   // root of cell a
  logic       phase_r, phase_nxt;
  logic       merged_r, merged_nxt;
  idx_t       start;

  assign start    = phase_r ? b_r : a_r;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    cmd_nxt    = cmd_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    r_nxt      = r_r;
    c_nxt      = c_r;
    ra_nxt     = ra_r;
    phase_nxt  = phase_r;
    merged_nxt = merged_r;
    mem_req    = '{we: 1'b0, waddr: c_r, wdata: r_r, raddr: r_r};
    res        = '{valid: 1'b0, root: ra_r, merged: merged_r};

    case (state_r)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        mem_req.wdata = clr_r;
        clr_nxt       = clr_r + idx_t'(1);
        if (clr_r == LastCell) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_cmd;
          a_nxt      = in_a;
          b_nxt      = in_b;
          phase_nxt  = 1'b0;
          merged_nxt = 1'b0;
          if (in_grid(in_a)) begin
            r_nxt         = in_a;
            mem_req.raddr = in_a;
            state_nxt     = S_WALK;
          end else begin
            ra_nxt    = in_a;
            state_nxt = S_DONE;
          end
        end
      end
      S_WALK: begin
        if ((rd_data == r_r) || !in_grid(rd_data)) begin
          // Root found; compress the path from the start cell.
          c_nxt = start;
          if (start != r_r) begin
            mem_req.raddr = start;
            state_nxt     = S_COMP;
          end else if (!phase_r) begin
            ra_nxt = r_r;
            if ((cmd_r == CMD_JOIN) && in_grid(b_r)) begin
              phase_nxt     = 1'b1;
              r_nxt         = b_r;
              mem_req.raddr = b_r;
            end else begin
              state_nxt = S_DONE;
            end
          end else begin
            state_nxt = S_LINK;
          end
        end else begin
          r_nxt         = rd_data;
          mem_req.raddr = rd_data;
        end
      end
      S_COMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = c_r;
        mem_req.wdata = r_r;
        if (rd_data != r_r) begin
          c_nxt         = rd_data;
          mem_req.raddr = rd_data;
        end else if (!phase_r) begin
          ra_nxt = r_r;
          if ((cmd_r == CMD_JOIN) && in_grid(b_r)) begin
            phase_nxt     = 1'b1;
            r_nxt         = b_r;
            mem_req.raddr = b_r;
            state_nxt     = S_WALK;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        if (r_r != ra_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = r_r;
          mem_req.wdata = ra_r;
          merged_nxt    = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          res.valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    r_r      <= r_nxt;
    c_r      <= c_nxt;
    ra_r     <= ra_nxt;
    merged_r <= merged_nxt;
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> state_r == S_CLEAR)
    else $error("sequencer did not start a clearing pass after reset");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !mem_req.we)
    else $error("parent table written while idle");

  a_merge_join: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && merged_r |-> cmd_r == CMD_JOIN)
    else $error("merge reported for a find");

  a_walk_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) || (state_r == S_COMP) |-> in_grid(r_r))
    else $error("walk left the grid");

endmodule

// ===== sv/union_find_path_compression.sv =====
// Operation: a find walks from cell a to its root, then rewrites each cell on the
// walked path to point at the root; a join does the same for cell b and then links
// the two roots when they differ. Throughput: one item at a time, a new transfer
// is taken once the result has moved to the output register.
// Reset: synchronous, active low; a clearing pass over GRID_WIDTH*GRID_HEIGHT
// cells (at most 1024) then makes every cell its own root before input is taken.
`timescale 1ns / 1ps

module union_find_path_compression #(
  parameter int GRID_WIDTH  = 32,
  parameter int GRID_HEIGHT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [9:0] cell_a, [19:10] cell_b, [23:20] zero
  input  logic        in_tuser,   // [0] command: find or join
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [9:0] root_index, [10] merged, [15:11] zero
);
  import ufpc_pkg::*;

  // Cells beyond the table depth never take part; the cell count is capped.
  localparam int CellProduct = GRID_WIDTH * GRID_HEIGHT;
  localparam int CellCount   = (CellProduct < TABLE_DEPTH) ? CellProduct : TABLE_DEPTH;

  mem_req_t mem_req;
  idx_t     rd_data;
  res_t     res;
  logic     out_free;

  // Result register, kept apart from the sequencer so that a finished result
  // can wait for the consumer while the sequencer goes back to idle.
  logic out_valid_r, out_valid_nxt;
  idx_t out_root_r;
  logic out_merged_r;

  assign out_free = !out_valid_r || out_tready;

  // The sequencer walks parent pointers one memory read per cycle, then
  // rewrites each cell on the path to point at the root.
  ufpc_seq #(
    .CELL_COUNT(CellCount)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tuser),
    .in_a     (in_tdata[9:0]),
    .in_b     (in_tdata[19:10]),
    .out_free (out_free),
    .res      (res),
    .mem_req  (mem_req),
    .rd_data  (rd_data)
  );

  ufpc_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_root_r   <= res.root;
      out_merged_r <= res.merged;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_merged_r, out_root_r};

endmodule

// ===== dv/union_find_path_compression_tb.sv =====
// Self-checking testbench for the union-find engine: a directed table, then random
// find/join traffic, checked against a behavioral parent table kept in the bench.
// Depends on ufpc_pkg and union_find_path_compression.
`timescale 1ns / 1ps

module union_find_path_compression_tb;
  import ufpc_pkg::*;

  localparam int GRID_W      = 32;
  localparam int GRID_H      = 32;
  localparam int CELL_LIMIT  = (GRID_W * GRID_H < TABLE_DEPTH) ? GRID_W * GRID_H : TABLE_DEPTH;
  localparam int RAND_ITEMS  = 730;
  localparam int QUIET_ITEMS = 60;   // last random items run with no idling on either side
  localparam int HOLD_CYCLES = 200;  // one long receiver hold-off to back up the input
  localparam int DRAIN_WAIT  = 64;
  localparam int DIR_ROWS    = 22;
  localparam int EXP_DEPTH   = 1024;

  typedef logic [9:0] slot_t;

  typedef struct packed {
    idx_t root;
    logic merged;
  } uf_result_t;

  typedef struct packed {
    logic       cmd;
    idx_t       cell_a;
    idx_t       cell_b;
    logic       fixed;      // expected result typed into the row
    uf_result_t fixed_res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [9:0] cell_a, [19:10] cell_b, [23:20] zero
  logic        in_tuser;   // [0] command
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [9:0] root_index, [10] merged, [15:11] zero

  // Behavioral copy of the parent table and the results still owed by the block,
  // kept as a ring with separate write and read pointers.
  idx_t       uf_parent [TABLE_DEPTH];
  uf_result_t exp_slots [EXP_DEPTH];
  slot_t      exp_wr = '0;
  slot_t      exp_rd = '0;
  dir_row_t   dir_rows [DIR_ROWS];
  int         mismatches = 0;
  bit         quiet = 1'b0;
  bit         long_hold_req = 1'b0;

  union_find_path_compression #(
    .GRID_WIDTH (GRID_W),
    .GRID_HEIGHT(GRID_H)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // Root of an in-grid cell; every cell on the walked path is pointed at the root.
  function automatic idx_t root_of(idx_t c);
    idx_t r;
    idx_t p;
    idx_t nxt;
    int   steps;
    r = c;
    steps = 0;
    while (steps < CELL_LIMIT) begin
      p = uf_parent[r];
      if (p == r || p >= CELL_LIMIT) break;
      r = p;
      steps++;
    end
    steps = 0;
    while (c != r && steps < CELL_LIMIT) begin
      nxt = uf_parent[c];
      uf_parent[c] = r;
      c = nxt;
      steps++;
    end
    return r;
  endfunction

  function automatic uf_result_t apply_command(logic cmd, idx_t a, idx_t b);
    uf_result_t res;
    idx_t       rb;
    res.merged = 1'b0;
    res.root = (a < CELL_LIMIT) ? root_of(a) : a;
    if (cmd == CMD_JOIN && a < CELL_LIMIT && b < CELL_LIMIT) begin
      rb = root_of(b);
      if (res.root != rb) begin
        uf_parent[rb] = res.root;
        res.merged = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic dir_row_t row(logic cmd, int a, int b, logic fixed = 1'b0,
                                   int root = 0, logic merged = 1'b0);
    return {cmd, idx_t'(a), idx_t'(b), fixed, idx_t'(root), merged};
  endfunction

  // Offers one item, possibly after a short idle burst, and records its expected
  // result once the transfer has happened. Called at a rising edge.
  task automatic send_item(input logic cmd, input idx_t a, input idx_t b,
                           input logic fixed = 1'b0,
                           input uf_result_t fixed_res = '0);
    int         gap;
    uf_result_t res;
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 24'($urandom);
      in_tuser  <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0, b, a};
    do @(posedge clk); while (!in_tready);
    res = apply_command(cmd, a, b);
    exp_slots[exp_wr] = fixed ? fixed_res : res;
    exp_wr = exp_wr + slot_t'(1);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (long_hold_req && !hold_done) begin
        out_tready <= 1'b0;
        stall_left = HOLD_CYCLES - 1;
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result checker: each transfer on the output is matched against the oldest
  // expectation.
  always @(posedge clk) begin
    uf_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_rd == exp_wr) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: root %0d merged %0b", out_tdata[9:0], out_tdata[10]);
      end else begin
        want = exp_slots[exp_rd];
        exp_rd = exp_rd + slot_t'(1);
        if (out_tdata[9:0] !== want.root || out_tdata[10] !== want.merged) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected root %0d merged %0b, got root %0d merged %0b",
                     want.root, want.merged, out_tdata[9:0], out_tdata[10]);
        end
      end
    end
  end

  initial begin
    int   i;
    int   k;
    int   j;
    int   base;
    int   span;
    bit   chain;
    bit   wide;
    logic cmd;
    idx_t a;
    idx_t b;

    for (i = 0; i < TABLE_DEPTH; i++) uf_parent[i] = idx_t'(i);

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= CMD_FIND;

    // Directed rows: extremes of the index bits, both commands, same-set joins,
    // the cell_b field ignored by find, and a chain that path compression flattens.
    dir_rows = '{
      row(CMD_FIND,    0,    0, 1'b1,    0, 1'b0),
      row(CMD_FIND, 1023, 1023, 1'b1, 1023, 1'b0),
      row(CMD_FIND,  682,  341, 1'b1,  682, 1'b0),
      row(CMD_FIND,  341,  682, 1'b1,  341, 1'b0),
      row(CMD_JOIN,    0, 1023, 1'b1,    0, 1'b1),
      row(CMD_FIND, 1023,    0, 1'b1,    0, 1'b0),
      row(CMD_JOIN, 1023,    0, 1'b1,    0, 1'b0),
      row(CMD_JOIN,    5,    5, 1'b1,    5, 1'b0),
      row(CMD_JOIN,  341,  682, 1'b1,  341, 1'b1),
      row(CMD_JOIN,   11,   10),
      row(CMD_JOIN,   12,   11),
      row(CMD_JOIN,   13,   12),
      row(CMD_JOIN,   14,   13),
      row(CMD_JOIN,   15,   14),
      row(CMD_FIND,   10,    0),
      row(CMD_FIND,   12,    0),
      row(CMD_JOIN,   20,   10),
      row(CMD_JOIN,   10,   20),
      row(CMD_JOIN, 1023,   15),
      row(CMD_FIND,   14,    0),
      row(CMD_JOIN,  682,   11),
      row(CMD_FIND, 1022,    1)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++)
      send_item(dir_rows[i].cmd, dir_rows[i].cell_a, dir_rows[i].cell_b,
                dir_rows[i].fixed, dir_rows[i].fixed_res);

    // Random part: traffic stays inside a small window of cells for a while so that
    // sets grow, trees deepen and same-set joins happen; some windows open with a
    // chain of joins, and some items range over the whole index space.
    base = 0;
    span = 16;
    chain = 1'b0;
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       span = 16;
          1:       span = 32;
          default: span = 96;
        endcase
        base = $urandom_range(0, TABLE_DEPTH - span);
        chain = ($urandom_range(0, 2) == 0);
      end
      if (k == 300) long_hold_req = 1'b1;
      if (k == RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;

      j = k % 40;
      wide = ($urandom_range(0, 7) == 0);
      if (chain && j < 12) begin
        if (j < 11) begin
          cmd = CMD_JOIN;
          a = idx_t'(base + j + 1);
          b = idx_t'(base + j);
        end else begin
          cmd = CMD_FIND;
          a = idx_t'(base);
          b = idx_t'($urandom);
        end
      end else begin
        cmd = ($urandom_range(0, 99) < 55) ? CMD_JOIN : CMD_FIND;
        a = wide ? idx_t'($urandom) : idx_t'(base + $urandom_range(0, span - 1));
        b = wide ? idx_t'($urandom) : idx_t'(base + $urandom_range(0, span - 1));
      end
      send_item(cmd, a, b);
    end
    in_tvalid <= 1'b0;

    while (exp_rd != exp_wr) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0 && exp_rd == exp_wr) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ufpc_pkg.sv
sv/ufpc_mem.sv
sv/ufpc_seq.sv
sv/union_find_path_compression.sv
dv/union_find_path_compression_tb.sv
